@@ rtl/assert_macros.svh @@
// assertion macros used by rmt_seq
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property checked on every clock edge out of reset
`define ASSERT_CLK(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("assertion failed");
// condition that must never hold out of reset
`define ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
	else $error("forbidden condition");
`else
`define ASSERT_CLK(lbl, prop)
`define ASSERT_NEVER(lbl, cond)
`endif
`endif

@@ rtl/rmt_pkg.sv @@
// types and constants of the range add / range max tree
package rmt_pkg;
	localparam int CFG_W            = 11;
	localparam int IDX_W            = 11;
	localparam int ADD_W            = 32;
	localparam int DATA_W           = 64;
	localparam int DEF_MAX_ELEMENTS = 1024;
	localparam logic [CFG_W-1:0] COUNT_RESET = 11'd1024;

	typedef enum logic {
		FUNC_ADD   = 1'b0,
		FUNC_QUERY = 1'b1
	} func_t;

	typedef struct packed {
		func_t                    func;
		logic [IDX_W-1:0]         range_low;
		logic [IDX_W-1:0]         range_high;
		logic signed [ADD_W-1:0]  add_value;
	} req_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD,
		ST_SETTLE,
		ST_WMAX,
		ST_CH1,
		ST_CH2,
		ST_DECIDE,
		ST_RET,
		ST_CMB0,
		ST_CMB1,
		ST_CMB2,
		ST_FIN
	} seq_state_t;
endpackage

@@ rtl/rmt_mem.sv @@
// node memory with one write port and one registered read port
module rmt_mem #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12,
	parameter int DW    = 64
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);
	logic [DW-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule

@@ rtl/rmt_seq.sv @@
// tree walk sequencer with explicit range stack and shared node datapath
`include "assert_macros.svh"
module rmt_seq import rmt_pkg::*; #(
	parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  req_t              req,
	output logic              idle,
	input  logic [CFG_W-1:0]  count,
	output logic              res_valid,
	input  logic              res_ready,
	output logic [DATA_W-1:0] res_data
);
	localparam int NSLOTS = 4 * MAX_ELEMENTS;
	localparam int NW     = $clog2(NSLOTS);
	localparam int IW     = $clog2(MAX_ELEMENTS + 1);
	localparam int CW     = (IW > IDX_W) ? IW : IDX_W;
	localparam int DEP    = $clog2(MAX_ELEMENTS) + 1;
	localparam int LW     = (DEP > 1) ? $clog2(DEP) : 1;
	localparam logic [CW-1:0] MAX_C = CW'(MAX_ELEMENTS);

	seq_state_t state_q, state_d;

	logic [NW-1:0]     node_q, clr_q;
	logic [CW-1:0]     lo_q, hi_q, a_q, b_q;
	logic [LW-1:0]     lvl_q;
	logic [CW-1:0]     stk_lo_q [DEP];
	logic [CW-1:0]     stk_hi_q [DEP];
	func_t             func_q;
	logic [DATA_W-1:0] amt_q, acc_q, delta_q, m_q;
	logic              outr_q, cov_q;

	// memory ports
	logic              max_we, pend_we;
	logic [NW-1:0]     max_wa, pend_wa, max_ra, pend_ra;
	logic [DATA_W-1:0] max_wd, pend_wd, max_rd, pend_rd;

	// active element count, zero taken as one, saturated at capacity
	logic [CW-1:0] cnt_ext, n_act;
	assign cnt_ext = CW'(count);
	assign n_act   = (cnt_ext == '0) ? CW'(1) : ((cnt_ext > MAX_C) ? MAX_C : cnt_ext);

	// split points of the current node and of its parent
	logic [CW-1:0] mid, plo, phi, pmid;
	logic [LW-1:0] lvl_up;
	assign mid    = CW'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);
	assign lvl_up = lvl_q - LW'(1);
	assign plo    = stk_lo_q[lvl_up];
	assign phi    = stk_hi_q[lvl_up];
	assign pmid   = CW'(({1'b0, plo} + {1'b0, phi}) >> 1);

	logic leaf;
	assign leaf = (lo_q == hi_q);

	logic [NW-1:0] left_n, right_n;
	assign left_n  = {node_q[NW-2:0], 1'b0};
	assign right_n = {node_q[NW-2:0], 1'b1};

	logic [DATA_W-1:0] m_sum;
	assign m_sum = m_q + delta_q;

	function automatic logic sgt(input logic [DATA_W-1:0] x, input logic [DATA_W-1:0] y);
		sgt = $signed(x) > $signed(y);
	endfunction

	rmt_mem #(.DEPTH(NSLOTS), .AW(NW), .DW(DATA_W)) u_max (
		.clk(clk), .we(max_we), .waddr(max_wa), .wdata(max_wd),
		.raddr(max_ra), .rdata(max_rd)
	);
	rmt_mem #(.DEPTH(NSLOTS), .AW(NW), .DW(DATA_W)) u_pend (
		.clk(clk), .we(pend_we), .waddr(pend_wa), .wdata(pend_wd),
		.raddr(pend_ra), .rdata(pend_rd)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and memory control
	always_comb begin
		state_d = state_q;
		max_we  = 1'b0;
		pend_we = 1'b0;
		max_wa  = node_q;
		pend_wa = node_q;
		max_wd  = m_sum;
		pend_wd = '0;
		max_ra  = node_q;
		pend_ra = node_q;
		case (state_q)
			ST_CLEAR: begin
				max_we  = 1'b1;
				pend_we = 1'b1;
				max_wa  = clr_q;
				pend_wa = clr_q;
				max_wd  = '0;
				if (clr_q == NW'(NSLOTS - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (req_valid) begin
					if (CW'(req.range_low) > CW'(req.range_high)) begin
						state_d = (req.func == FUNC_QUERY) ? ST_FIN : ST_IDLE;
					end else begin
						state_d = ST_RD;
					end
				end
			end
			ST_RD:     state_d = ST_SETTLE;
			ST_SETTLE: state_d = ST_WMAX;
			ST_WMAX: begin
				max_we  = 1'b1;
				pend_we = 1'b1;
				pend_ra = left_n;
				state_d = (!leaf && delta_q != '0) ? ST_CH1 : ST_DECIDE;
			end
			ST_CH1: begin
				pend_we = 1'b1;
				pend_wa = left_n;
				pend_wd = pend_rd + delta_q;
				pend_ra = right_n;
				state_d = ST_CH2;
			end
			ST_CH2: begin
				pend_we = 1'b1;
				pend_wa = right_n;
				pend_wd = pend_rd + delta_q;
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				state_d = (outr_q || cov_q) ? ST_RET : ST_RD;
			end
			ST_RET: begin
				if (lvl_q == '0) begin
					state_d = (func_q == FUNC_QUERY) ? ST_FIN : ST_IDLE;
				end else if (!node_q[0]) begin
					state_d = ST_RD;
				end else begin
					state_d = (func_q == FUNC_ADD) ? ST_CMB0 : ST_RET;
				end
			end
			ST_CMB0: begin
				max_ra  = left_n;
				state_d = ST_CMB1;
			end
			ST_CMB1: begin
				max_ra  = right_n;
				state_d = ST_CMB2;
			end
			ST_CMB2: begin
				max_we  = 1'b1;
				max_wd  = sgt(m_q, max_rd) ? m_q : max_rd;
				state_d = ST_RET;
			end
			ST_FIN: begin
				if (res_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// walk registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			lvl_q <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: clr_q <= clr_q + NW'(1);
				ST_IDLE: begin
					func_q <= req.func;
					a_q    <= CW'(req.range_low);
					b_q    <= CW'(req.range_high);
					amt_q  <= DATA_W'(req.add_value);
					acc_q  <= '0;
					node_q <= NW'(1);
					lo_q   <= CW'(1);
					hi_q   <= n_act;
					lvl_q  <= '0;
				end
				ST_RD: begin
					outr_q <= (lo_q > b_q) || (hi_q < a_q);
					cov_q  <= (a_q <= lo_q) && (hi_q <= b_q);
				end
				ST_SETTLE: begin
					m_q     <= max_rd;
					delta_q <= pend_rd +
						((cov_q && !outr_q && func_q == FUNC_ADD) ? amt_q : '0);
				end
				ST_WMAX: m_q <= m_sum;
				ST_DECIDE: begin
					if (!outr_q && cov_q) begin
						if (func_q == FUNC_QUERY && sgt(m_q, acc_q)) acc_q <= m_q;
					end else if (!outr_q) begin
						stk_lo_q[lvl_q] <= lo_q;
						stk_hi_q[lvl_q] <= hi_q;
						lvl_q  <= lvl_q + LW'(1);
						node_q <= left_n;
						hi_q   <= mid;
					end
				end
				ST_RET: begin
					if (lvl_q != '0) begin
						if (!node_q[0]) begin
							node_q <= {node_q[NW-1:1], 1'b1};
							lo_q   <= pmid + CW'(1);
							hi_q   <= phi;
						end else begin
							node_q <= {1'b0, node_q[NW-1:1]};
							lo_q   <= plo;
							hi_q   <= phi;
							lvl_q  <= lvl_up;
						end
					end
				end
				ST_CMB1: m_q <= max_rd;
				default: ;
			endcase
		end
	end

	assign idle      = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_FIN);
	assign res_data  = acc_q;

	`ASSERT_CLK(a_node_nonzero, (state_q == ST_RD) |-> (node_q != '0))
	`ASSERT_CLK(a_range_order, (state_q == ST_RD) |-> (lo_q <= hi_q))
	`ASSERT_CLK(a_result_query, res_valid |-> (func_q == FUNC_QUERY))
	`ASSERT_CLK(a_clear_done, (state_q == ST_CLEAR && state_d == ST_IDLE) |-> (clr_q == NW'(NSLOTS - 1)))
endmodule

@@ rtl/range_add_range_max_tree.sv @@
// top level of the range add / range max tree
// Keeps signed 64-bit elements 1..element_count, all zero after reset.
// Input stream s_axis: tuser = func (0 add, 1 query), tdata = range_low,
// range_high, add_value. An add updates every element in the inclusive range
// and gives no output; a query gives one m_axis transaction carrying
// max(0, maximum over the range). cfg_* writes element_count, taken only
// while the block is idle, ahead of an input transaction offered with it.
// One item at a time: tready is high only while the walker is idle and no
// cfg write is offered. Each visited tree node passes through the shared
// node datapath (one memory read, add and write-back, child pending
// updates); an add also rebuilds each parent maximum on the way back up.
// An item walks about four nodes per level, or the root alone when it
// covers or misses the range; the single read port of each node memory
// sets the pace. Ranges with low above high skip the tree walk. After
// reset a clearing pass writes zeros to all 4*MAX_ELEMENTS node slots,
// one per cycle, before tready rises. The result sits in an output
// register; a stalled receiver holds it and the block waits with the next
// query result, while adds keep flowing.
module range_add_range_max_tree import rmt_pkg::*; #(
	parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [55:0]       s_axis_tdata,   // range_low, range_high, add_value, zero pad
	input  logic              s_axis_tuser,   // func
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [DATA_W-1:0] m_axis_tdata,   // max_value
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_W-1:0]  cfg_data
);
	logic [CFG_W-1:0]  count_q;
	logic              out_valid_q;
	logic [DATA_W-1:0] out_data_q;
	logic              res_valid, res_ready, idle;
	logic [DATA_W-1:0] res_data;
	req_t              req;

	// unpack the input transaction
	assign req.func       = func_t'(s_axis_tuser);
	assign req.range_low  = s_axis_tdata[10:0];
	assign req.range_high = s_axis_tdata[21:11];
	assign req.add_value  = s_axis_tdata[53:22];

	// element count register
	assign cfg_ready = idle;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= COUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			count_q <= cfg_data;
		end
	end

	// output register
	assign res_ready = !out_valid_q || m_axis_tready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (res_ready && res_valid) out_data_q <= res_data;
	end

	assign s_axis_tready = idle && !cfg_valid;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	rmt_seq #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_axis_tvalid && !cfg_valid),
		.req       (req),
		.idle      (idle),
		.count     (count_q),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data)
	);
endmodule
